[rtl/core/assert_macros.svh]
// Assertion helpers for the RTL in this folder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ELCT_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Check that a condition is followed by another on the next edge.
`define ELCT_ASSERT_NEXT(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

[rtl/core/elct_pkg.sv]
package elct_pkg;

   // Pipeline depth, one register per stage
   localparam int NUM_STAGES = 12;

   // Seconds to days and time of day
   localparam logic [31:0] SECS_PER_DAY   = 32'd86400;
   localparam logic [15:0] DAY_RECIP      = 16'd49710;   // floor(2^32 / 86400)
   localparam logic [16:0] SECS_PER_HOUR  = 17'd3600;
   localparam logic [5:0]  HOUR_RECIP     = 6'd36;       // floor(2^17 / 3600)
   localparam logic [11:0] SECS_PER_MIN   = 12'd60;
   localparam logic [6:0]  MIN_RECIP      = 7'd68;       // floor(2^12 / 60)

   // Day count to day of era (eras of 400 years from March 0000)
   localparam logic [15:0] ERA5_FIRST_DAY = 16'd11017;   // first day of era 5
   localparam logic [17:0] ERA4_DOE_BIAS  = 18'd135080;  // 719468 - 4 * 146097

   // Year of era
   localparam logic [17:0] DAYS_PER_4Y    = 18'd1460;
   localparam logic [7:0]  RECIP_4Y       = 8'd179;      // floor(2^18 / 1460)
   localparam logic [17:0] DAYS_PER_100Y  = 18'd36524;
   localparam logic [17:0] DAYS_ERA_LAST  = 18'd146096;
   localparam logic [17:0] DAYS_PER_YEAR  = 18'd365;
   localparam logic [9:0]  RECIP_YEAR     = 10'd718;     // floor(2^18 / 365)

   // Year bases of the two eras that a 32-bit count can reach
   localparam logic [11:0] ERA4_BASE_YEAR = 12'd1600;
   localparam logic [11:0] ERA5_BASE_YEAR = 12'd2000;

   // Months counted from March
   localparam logic [3:0]  NUM_MONTHS     = 4'd12;
   localparam logic [3:0]  FIRST_JAN_MP   = 4'd10;

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } hms_type;

   // First day of year (from March 1) of each month counted from March
   function automatic logic [8:0] month_start(input logic [3:0] mp);
      logic [8:0] start;
      unique case (mp)
         4'd0:    start = 9'd0;
         4'd1:    start = 9'd31;
         4'd2:    start = 9'd61;
         4'd3:    start = 9'd92;
         4'd4:    start = 9'd122;
         4'd5:    start = 9'd153;
         4'd6:    start = 9'd184;
         4'd7:    start = 9'd214;
         4'd8:    start = 9'd245;
         4'd9:    start = 9'd275;
         4'd10:   start = 9'd306;
         4'd11:   start = 9'd337;
         default: start = 9'd0;
      endcase
      return start;
   endfunction

endpackage

[rtl/core/epoch_to_local_civil_time_unit.sv]
// Local civil date and time from a 32-bit UTC seconds count.
//
// Input channel (req_): req_utc_seconds, taken at an edge with req_valid high
// and req_stall low. Result channel (rsp_): year, month, day of month, hour,
// minute and second, taken at an edge with rsp_valid high and rsp_stall low.
// csr_wr_en writes the signed time-zone offset in minutes from csr_wr_data;
// write it only while no word is in flight. The offset is applied as minutes
// times 60, and the local seconds wrap modulo 2^32.
// A word accepted at the input passes through a 12-stage pipeline and shows
// on rsp_ from the last stage. Throughput is one word per cycle while the
// receiver does not stall. Each reciprocal multiply estimate is corrected in
// the stage after it.
// A stall from the receiver holds the output word; earlier stages keep
// advancing into empty slots, so req_stall rises only once all 12 stages
// hold a word. Reset empties the pipeline and clears the offset to zero.
module epoch_to_local_civil_time_unit
   import elct_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic signed [10:0] csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [31:0]        req_utc_seconds,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [11:0]        rsp_year,
   output logic [3:0]         rsp_month,
   output logic [4:0]         rsp_day_of_month,
   output logic [4:0]         rsp_hour,
   output logic [5:0]         rsp_minute,
   output logic [5:0]         rsp_second
);

`include "assert_macros.svh"

   // Offset in seconds, signed
   logic signed [16:0] off_sec_ff, off_sec_in;
   logic signed [16:0] off_ext;

   // Stage valids and per-stage advance
   logic [1:NUM_STAGES]   v_ff;
   logic [1:NUM_STAGES+1] adv;

   // Stage payloads
   logic [31:0] s1_local_ff, s1_local_in;
   logic [31:0] s2_local_ff;
   logic [15:0] s2_dq_ff, s2_dq_in;
   logic [15:0] s3_days_ff, s3_days_in;
   logic [16:0] s3_sod_ff, s3_sod_in;
   logic [4:0]  s4_hq_ff, s4_hq_in;
   logic [16:0] s4_sod_ff;
   logic [17:0] doe_ff [4:9];
   logic [17:0] doe_in;
   logic        era5_ff [4:NUM_STAGES];
   logic        era5_in;
   logic [4:0]  s5_hour_ff, s5_hour_in;
   logic [11:0] s5_soh_ff, s5_soh_in;
   logic [6:0]  s5_q4y_ff, s5_q4y_in;
   logic [2:0]  s5_qcent_ff, s5_qcent_in;
   logic        s5_qlast_ff, s5_qlast_in;
   logic [4:0]  s6_hour_ff;
   logic [11:0] s6_soh_ff;
   logic [5:0]  s6_mq_ff, s6_mq_in;
   logic [6:0]  s6_q4y_ff, s6_q4y_in;
   logic [2:0]  s6_qcent_ff;
   logic        s6_qlast_ff;
   hms_type     hms_ff [7:NUM_STAGES];
   hms_type     hms_in;
   logic [17:0] s7_n_ff, s7_n_in;
   logic [17:0] s8_n_ff;
   logic [8:0]  s8_ye_ff, s8_ye_in;
   logic [8:0]  s9_yoe_ff, s9_yoe_in;
   logic [8:0]  s10_yoe_ff;
   logic [8:0]  s10_doy_ff, s10_doy_in;
   logic [8:0]  s11_yoe_ff;
   logic [8:0]  s11_doy_ff;
   logic [3:0]  s11_mp_ff, s11_mp_in;
   logic [11:0] s12_year_ff, s12_year_in;
   logic [3:0]  s12_month_ff, s12_month_in;
   logic [4:0]  s12_dom_ff, s12_dom_in;

   // Scratch terms
   logic [47:0] day_prod;
   logic [31:0] day_rem;
   logic [22:0] hour_prod;
   logic [16:0] hour_rem;
   logic [25:0] q4y_prod;
   logic [17:0] q4y_rem;
   logic [18:0] min_prod;
   logic [11:0] min_rem;
   logic [27:0] year_prod;
   logic [17:0] year_rem;
   logic [1:0]  yoe_c100;
   logic [17:0] yoe_days;

   // Terms for the checks on the result word
   logic        date_ok;
   logic        time_ok;
   logic        tail_blocked;

   // Convert a written offset in minutes to seconds
   always_comb begin
      off_ext    = {{6{csr_wr_data[10]}}, csr_wr_data};
      off_sec_in = (off_ext <<< 6) - (off_ext <<< 2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_sec_ff <= '0;
      end else if (csr_wr_en) begin
         off_sec_ff <= off_sec_in;
      end
   end

   // A stage advances when it is empty or the stage after it advances
   always_comb begin
      adv[NUM_STAGES+1] = !rsp_stall;
      for (int k = NUM_STAGES; k >= 1; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
   end

   assign req_stall = !adv[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[1]) begin
            v_ff[1] <= req_valid;
         end
         for (int k = 2; k <= NUM_STAGES; k++) begin
            if (adv[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // Datapath next values
   always_comb begin
      // Stage 1: local seconds, wrapping modulo 2^32
      s1_local_in = req_utc_seconds + {{15{off_sec_ff[16]}}, off_sec_ff};

      // Stage 2: day estimate, low by at most one
      day_prod = 48'(s1_local_ff) * 48'(DAY_RECIP);
      s2_dq_in = day_prod[47:32];

      // Stage 3: correct the day count, keep seconds of day
      day_rem = s2_local_ff - (32'(s2_dq_ff) * SECS_PER_DAY);
      if (day_rem >= SECS_PER_DAY) begin
         s3_days_in = s2_dq_ff + 16'd1;
         s3_sod_in  = 17'(day_rem - SECS_PER_DAY);
      end else begin
         s3_days_in = s2_dq_ff;
         s3_sod_in  = day_rem[16:0];
      end

      // Stage 4: day of era and hour estimate
      if (s3_days_ff < ERA5_FIRST_DAY) begin
         doe_in  = 18'(s3_days_ff) + ERA4_DOE_BIAS;
         era5_in = 1'b0;
      end else begin
         doe_in  = 18'(s3_days_ff) - 18'(ERA5_FIRST_DAY);
         era5_in = 1'b1;
      end
      hour_prod = 23'(s3_sod_ff) * 23'(HOUR_RECIP);
      s4_hq_in  = hour_prod[21:17];

      // Stage 5: correct the hour; estimate four-year cycles, count centuries
      hour_rem = s4_sod_ff - 17'(17'(s4_hq_ff) * SECS_PER_HOUR);
      if (hour_rem >= SECS_PER_HOUR) begin
         s5_hour_in = s4_hq_ff + 5'd1;
         s5_soh_in  = 12'(hour_rem - SECS_PER_HOUR);
      end else begin
         s5_hour_in = s4_hq_ff;
         s5_soh_in  = hour_rem[11:0];
      end
      q4y_prod    = 26'(doe_ff[4]) * 26'(RECIP_4Y);
      s5_q4y_in   = q4y_prod[24:18];
      s5_qcent_in = 3'(doe_ff[4] >= DAYS_PER_100Y)
                  + 3'(doe_ff[4] >= 18'(2 * DAYS_PER_100Y))
                  + 3'(doe_ff[4] >= 18'(3 * DAYS_PER_100Y))
                  + 3'(doe_ff[4] >= 18'(4 * DAYS_PER_100Y));
      s5_qlast_in = (doe_ff[4] == DAYS_ERA_LAST);

      // Stage 6: minute estimate; correct four-year cycles
      min_prod = 19'(s5_soh_ff) * 19'(MIN_RECIP);
      s6_mq_in = min_prod[17:12];
      q4y_rem  = doe_ff[5] - 18'(18'(s5_q4y_ff) * DAYS_PER_4Y);
      if (q4y_rem >= DAYS_PER_4Y) begin
         s6_q4y_in = s5_q4y_ff + 7'd1;
      end else begin
         s6_q4y_in = s5_q4y_ff;
      end

      // Stage 7: correct the minute; day of era less leap days
      min_rem = s6_soh_ff - 12'(12'(s6_mq_ff) * SECS_PER_MIN);
      hms_in.hour = s6_hour_ff;
      if (min_rem >= SECS_PER_MIN) begin
         hms_in.minute = s6_mq_ff + 6'd1;
         hms_in.second = 6'(min_rem - SECS_PER_MIN);
      end else begin
         hms_in.minute = s6_mq_ff;
         hms_in.second = min_rem[5:0];
      end
      s7_n_in = doe_ff[6] - 18'(s6_q4y_ff) + 18'(s6_qcent_ff) - 18'(s6_qlast_ff);

      // Stage 8: year of era estimate
      year_prod = 28'(s7_n_ff) * 28'(RECIP_YEAR);
      s8_ye_in  = year_prod[26:18];

      // Stage 9: correct the year of era
      year_rem = s8_n_ff - 18'(18'(s8_ye_ff) * DAYS_PER_YEAR);
      if (year_rem >= DAYS_PER_YEAR) begin
         s9_yoe_in = s8_ye_ff + 9'd1;
      end else begin
         s9_yoe_in = s8_ye_ff;
      end

      // Stage 10: day of year from March 1
      yoe_c100 = 2'(s9_yoe_ff >= 9'd100) + 2'(s9_yoe_ff >= 9'd200)
               + 2'(s9_yoe_ff >= 9'd300);
      yoe_days = 18'(s9_yoe_ff) * DAYS_PER_YEAR + 18'(s9_yoe_ff >> 2) - 18'(yoe_c100);
      s10_doy_in = 9'(doe_ff[9] - yoe_days);

      // Stage 11: month counted from March
      s11_mp_in = 4'd0;
      for (int k = 1; k < 12; k++) begin
         if (s10_doy_ff >= month_start(4'(k))) begin
            s11_mp_in = 4'(k);
         end
      end

      // Stage 12: civil month, day and year
      s12_dom_in = 5'(s11_doy_ff - month_start(s11_mp_ff) + 9'd1);
      if (s11_mp_ff < FIRST_JAN_MP) begin
         s12_month_in = s11_mp_ff + 4'd3;
      end else begin
         s12_month_in = s11_mp_ff + 4'd3 - NUM_MONTHS;
      end
      s12_year_in = 12'(s11_yoe_ff)
                  + (era5_ff[11] ? ERA5_BASE_YEAR : ERA4_BASE_YEAR)
                  + 12'(s11_mp_ff >= FIRST_JAN_MP);
   end

   // Load each stage when it advances
   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s1_local_ff <= s1_local_in;
      end
      if (adv[2]) begin
         s2_local_ff <= s1_local_ff;
         s2_dq_ff    <= s2_dq_in;
      end
      if (adv[3]) begin
         s3_days_ff <= s3_days_in;
         s3_sod_ff  <= s3_sod_in;
      end
      if (adv[4]) begin
         doe_ff[4]  <= doe_in;
         era5_ff[4] <= era5_in;
         s4_hq_ff   <= s4_hq_in;
         s4_sod_ff  <= s3_sod_ff;
      end
      if (adv[5]) begin
         s5_hour_ff  <= s5_hour_in;
         s5_soh_ff   <= s5_soh_in;
         s5_q4y_ff   <= s5_q4y_in;
         s5_qcent_ff <= s5_qcent_in;
         s5_qlast_ff <= s5_qlast_in;
      end
      if (adv[6]) begin
         s6_hour_ff  <= s5_hour_ff;
         s6_soh_ff   <= s5_soh_ff;
         s6_mq_ff    <= s6_mq_in;
         s6_q4y_ff   <= s6_q4y_in;
         s6_qcent_ff <= s5_qcent_ff;
         s6_qlast_ff <= s5_qlast_ff;
      end
      if (adv[7]) begin
         hms_ff[7] <= hms_in;
         s7_n_ff   <= s7_n_in;
      end
      if (adv[8]) begin
         s8_n_ff  <= s7_n_ff;
         s8_ye_ff <= s8_ye_in;
      end
      if (adv[9]) begin
         s9_yoe_ff <= s9_yoe_in;
      end
      if (adv[10]) begin
         s10_yoe_ff <= s9_yoe_ff;
         s10_doy_ff <= s10_doy_in;
      end
      if (adv[11]) begin
         s11_yoe_ff <= s10_yoe_ff;
         s11_doy_ff <= s10_doy_ff;
         s11_mp_ff  <= s11_mp_in;
      end
      if (adv[12]) begin
         s12_year_ff  <= s12_year_in;
         s12_month_ff <= s12_month_in;
         s12_dom_ff   <= s12_dom_in;
      end
      // Carry day of era, era and time of day down the pipeline
      for (int k = 5; k <= 9; k++) begin
         if (adv[k]) begin
            doe_ff[k] <= doe_ff[k-1];
         end
      end
      for (int k = 5; k <= NUM_STAGES; k++) begin
         if (adv[k]) begin
            era5_ff[k] <= era5_ff[k-1];
         end
      end
      for (int k = 8; k <= NUM_STAGES; k++) begin
         if (adv[k]) begin
            hms_ff[k] <= hms_ff[k-1];
         end
      end
   end

   // Drive the result word
   assign rsp_valid        = v_ff[NUM_STAGES];
   assign rsp_year         = s12_year_ff;
   assign rsp_month        = s12_month_ff;
   assign rsp_day_of_month = s12_dom_ff;
   assign rsp_hour         = hms_ff[NUM_STAGES].hour;
   assign rsp_minute       = hms_ff[NUM_STAGES].minute;
   assign rsp_second       = hms_ff[NUM_STAGES].second;

   // Range of each result field, and a blocked word behind the output
   assign date_ok = rsp_month != 4'd0 && rsp_month <= 4'd12 && rsp_day_of_month != 5'd0
                 && rsp_year >= 12'd1970 && rsp_year <= 12'd2106;
   assign time_ok = rsp_hour < 5'd24 && rsp_minute < 6'd60 && rsp_second < 6'd60;
   assign tail_blocked = v_ff[NUM_STAGES-1] && !adv[NUM_STAGES];

   // Fields of a delivered word stay within the calendar
   `ELCT_ASSERT(a_date_in_range, !rsp_valid || date_ok, "result date out of range")
   `ELCT_ASSERT(a_time_in_range, !rsp_valid || time_ok, "result time out of range")
   // Input back-pressure only when every stage holds a word
   `ELCT_ASSERT(a_stall_when_full, !req_stall || (&v_ff), "input stalled with an empty stage")
   // A word blocked in the next-to-last stage is not dropped
   `ELCT_ASSERT_NEXT(a_blocked_word_held, tail_blocked, v_ff[NUM_STAGES-1], "blocked word lost")

endmodule
